>>> rtl/sdspi_pkg.sv
// sdspi_pkg: shared types, codes and constants of the sd spi command/response engine
// no dependencies; imported by every module of the block

package sdspi_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_WAIT = 2'd1;
  localparam logic [1:0] ACT_RX   = 2'd2;

  // argument selection of a send-command item
  localparam logic [1:0] AM_ZERO       = 2'd0;
  localparam logic [1:0] AM_BLOCK      = 2'd1;
  localparam logic [1:0] AM_SECTOR_END = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_FRAME   = 2'd0;
  localparam logic [1:0] KIND_CAPTURE = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_BLOCK_LEN_LOG2   = 2'd0;
  localparam logic [1:0] REG_SECTOR_BLOCKS    = 2'd1;
  localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd2;

  localparam logic [3:0] RST_BLOCK_LEN_LOG2   = 4'd9;
  localparam logic [7:0] RST_SECTOR_BLOCKS    = 8'd1;
  localparam logic [7:0] RST_RESPONSE_TIMEOUT = 8'd10;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // frame bytes
  localparam logic [7:0] CMD_START_BIT = 8'h40;
  localparam logic [7:0] CRC_IDLE      = 8'h95;
  localparam logic [7:0] CRC_OTHER     = 8'h01;
  localparam logic [7:0] IDLE_BYTE     = 8'hFF;
  localparam int         FRAME_LEN     = 6;

  // response length cap, bounded by the width of the byte counter
  localparam int MAX_RESPONSE_BYTES = 32;
  localparam int LEN_CAP_INT = (MAX_RESPONSE_BYTES > 63) ? 63 :
                               ((MAX_RESPONSE_BYTES < 1) ? 1 : MAX_RESPONSE_BYTES);
  localparam logic [5:0] LEN_CAP = 6'(LEN_CAP_INT);

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ARG,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic [3:0] block_len_log2;
    logic [7:0] sector_blocks;
    logic [7:0] response_timeout;
  } cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  command_index;
    logic [31:0] term;
    logic [6:0]  addend;
    logic        dec;
    logic [5:0]  response_length;
    logic [7:0]  rx_byte;
  } entry_t;

endpackage

>>> rtl/sdspi_if.sv
// sdspi_in_if / sdspi_out_if: valid/ready channels of the engine
// no dependencies

interface sdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [5:0]  command_index;
  logic [1:0]  address_mode;
  logic [31:0] sector;
  logic [6:0]  block;
  logic [5:0]  response_length;
  logic [7:0]  rx_byte;

  modport source (
    output valid, action, command_index, address_mode, sector, block,
           response_length, rx_byte,
    input  ready
  );
  modport sink (
    input  valid, action, command_index, address_mode, sector, block,
           response_length, rx_byte,
    output ready
  );
endinterface

interface sdspi_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (
    output valid, out_kind, out_byte, out_last,
    input  ready
  );
  modport sink (
    input  valid, out_kind, out_byte, out_last,
    output ready
  );
endinterface

>>> rtl/sd_spi_command_response_engine_unit.sv
// sd spi command/response engine: command frames out, card responses collected
// used channels: in_ch (items in), out_ch (result bytes out), apb register port
//
// items enter on in_ch and are queued by the front part; the back part runs
// them one at a time in arrival order and places each result in an output
// register on out_ch, so an input transfer may proceed while a result waits
// - send command: six frame bytes, the first after the queue, the multiply
//   step, the shift step and the output register; then one byte per cycle
//   while out_ch is taken; no new item is taken until the frame is out
// - start wait and received byte: handled in the idle state, a result (if
//   any) in the output register; one item per cycle while out_ch takes them
// the queue holds QUEUE_DEPTH items; in_ch.ready drops when it is full
// a stalled out_ch freezes the back part, the queue then fills and stalls in_ch
// reset (rst_n low, synchronous) empties the queue, disarms the collector,
// drops out_ch.valid and loads register defaults: block_len_log2 9,
// sector_blocks 1, response_timeout 10
// registers: 0x0 block_len_log2, 0x4 sector_blocks, 0x8 response_timeout;
// write them only while the engine is idle

module sd_spi_command_response_engine_unit #(
  parameter int QUEUE_DEPTH = sdspi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  sdspi_in_if.sink                          in_ch,
  sdspi_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sdspi_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sdspi_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sdspi_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import sdspi_pkg::*;

  cfg_t   cfg;
  logic   q_pop;
  logic   q_valid;
  entry_t q_head;

  sdspi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sdspi_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  sdspi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/sdspi_cfg.sv
// sdspi_cfg: apb register file holding block length, sector size and timeout
// depends on sdspi_pkg

module sdspi_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sdspi_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [sdspi_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [sdspi_pkg::APB_DATA_W-1:0]  prdata,
  output logic                              pready,
  output sdspi_pkg::cfg_t                   cfg
);
  import sdspi_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_len_log2   <= RST_BLOCK_LEN_LOG2;
      cfg_r.sector_blocks    <= RST_SECTOR_BLOCKS;
      cfg_r.response_timeout <= RST_RESPONSE_TIMEOUT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BLOCK_LEN_LOG2:   cfg_r.block_len_log2   <= pwdata[3:0];
        REG_SECTOR_BLOCKS:    cfg_r.sector_blocks    <= pwdata[7:0];
        REG_RESPONSE_TIMEOUT: cfg_r.response_timeout <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLOCK_LEN_LOG2:   prdata = {28'd0, cfg_r.block_len_log2};
      REG_SECTOR_BLOCKS:    prdata = {24'd0, cfg_r.sector_blocks};
      REG_RESPONSE_TIMEOUT: prdata = {24'd0, cfg_r.response_timeout};
      default:              prdata = '0;
    endcase
  end

endmodule

>>> rtl/sdspi_front.sv
// sdspi_front: accepts input items, prepares the argument terms, queues them
// depends on sdspi_pkg and sdspi_in_if

module sdspi_front #(
  parameter int DEPTH = sdspi_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  sdspi_in_if.sink           in_ch,
  input  logic               q_pop,
  output logic               q_valid,
  output sdspi_pkg::entry_t  q_head
);
  import sdspi_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;
  entry_t           item;

  assign in_ch.ready = (cnt_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign pop         = q_pop && q_valid;
  assign q_head      = q_r[rd_ptr_r];

  // argument = ((term * sector_blocks) + addend) << block_len_log2, minus dec
  always_comb begin
    item.action          = in_ch.action;
    item.command_index   = in_ch.command_index;
    item.response_length = in_ch.response_length;
    item.rx_byte         = in_ch.rx_byte;
    case (in_ch.address_mode)
      AM_BLOCK: begin
        item.term   = in_ch.sector;
        item.addend = in_ch.block;
        item.dec    = 1'b0;
      end
      AM_SECTOR_END: begin
        item.term   = in_ch.sector + 32'd1;
        item.addend = '0;
        item.dec    = 1'b1;
      end
      default: begin
        item.term   = '0;
        item.addend = '0;
        item.dec    = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

>>> rtl/sdspi_back.sv
// sdspi_back: frame sequencer and response collector with the output register
// depends on sdspi_pkg and sdspi_out_if

module sdspi_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sdspi_pkg::cfg_t    cfg,
  input  logic               q_valid,
  input  sdspi_pkg::entry_t  q_head,
  output logic               q_pop,
  sdspi_out_if.source        out_ch
);
  import sdspi_pkg::*;

  bk_state_t   state_r, state_nxt;
  logic [5:0]  cmd_r, cmd_nxt;
  logic [31:0] prod_r, prod_nxt;
  logic        dec_r, dec_nxt;
  logic [31:0] arg_r, arg_nxt;
  logic [2:0]  idx_r, idx_nxt;

  logic        wait_active_r, wait_active_nxt;
  logic [5:0]  bytes_rem_r, bytes_rem_nxt;
  logic        cap_started_r, cap_started_nxt;
  logic [7:0]  tmo_left_r, tmo_left_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;

  logic        out_free;
  logic [39:0] mul_full;
  logic [5:0]  len_eff;
  logic [7:0]  tmo_dec;
  logic [5:0]  rem_dec;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_kind = out_kind_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

  assign mul_full = q_head.term * {24'd0, cfg.sector_blocks};
  assign len_eff  = (q_head.response_length == '0) ? 6'd1 :
                    ((q_head.response_length > LEN_CAP) ? LEN_CAP : q_head.response_length);
  assign tmo_dec  = (tmo_left_r != '0) ? tmo_left_r - 8'd1 : tmo_left_r;
  assign rem_dec  = (bytes_rem_r != '0) ? bytes_rem_r - 6'd1 : bytes_rem_r;

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    prod_nxt        = prod_r;
    dec_nxt         = dec_r;
    arg_nxt         = arg_r;
    idx_nxt         = idx_r;
    wait_active_nxt = wait_active_r;
    bytes_rem_nxt   = bytes_rem_r;
    cap_started_nxt = cap_started_r;
    tmo_left_nxt    = tmo_left_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_kind_nxt    = out_kind_r;
    out_byte_nxt    = out_byte_r;
    out_last_nxt    = out_last_r;
    q_pop           = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          case (q_head.action)
            ACT_SEND: begin
              cmd_nxt   = q_head.command_index;
              prod_nxt  = mul_full[31:0] + {25'd0, q_head.addend};
              dec_nxt   = q_head.dec;
              state_nxt = BK_ARG;
            end
            ACT_WAIT: begin
              cap_started_nxt = 1'b0;
              if (cfg.response_timeout == '0) begin
                wait_active_nxt = 1'b0;
                bytes_rem_nxt   = '0;
                tmo_left_nxt    = '0;
                out_valid_nxt   = 1'b1;
                out_kind_nxt    = KIND_TIMEOUT;
                out_byte_nxt    = '0;
                out_last_nxt    = 1'b1;
              end else begin
                wait_active_nxt = 1'b1;
                bytes_rem_nxt   = len_eff;
                tmo_left_nxt    = cfg.response_timeout;
              end
            end
            ACT_RX: begin
              if (wait_active_r) begin
                if (!cap_started_r && q_head.rx_byte == IDLE_BYTE) begin
                  tmo_left_nxt = tmo_dec;
                  if (tmo_dec == '0) begin
                    wait_active_nxt = 1'b0;
                    bytes_rem_nxt   = '0;
                    out_valid_nxt   = 1'b1;
                    out_kind_nxt    = KIND_TIMEOUT;
                    out_byte_nxt    = '0;
                    out_last_nxt    = 1'b1;
                  end
                end else begin
                  cap_started_nxt = 1'b1;
                  bytes_rem_nxt   = rem_dec;
                  out_valid_nxt   = 1'b1;
                  out_kind_nxt    = KIND_CAPTURE;
                  out_byte_nxt    = q_head.rx_byte;
                  out_last_nxt    = (rem_dec == '0);
                  if (rem_dec == '0) begin
                    wait_active_nxt = 1'b0;
                    cap_started_nxt = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end

      BK_ARG: begin
        arg_nxt   = (prod_r << cfg.block_len_log2) - {31'd0, dec_r};
        idx_nxt   = '0;
        state_nxt = BK_EMIT;
      end

      BK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FRAME;
          out_last_nxt  = 1'b0;
          case (idx_r)
            3'd0:    out_byte_nxt = {2'b00, cmd_r} | CMD_START_BIT;
            3'd1:    out_byte_nxt = arg_r[31:24];
            3'd2:    out_byte_nxt = arg_r[23:16];
            3'd3:    out_byte_nxt = arg_r[15:8];
            3'd4:    out_byte_nxt = arg_r[7:0];
            default: out_byte_nxt = (cmd_r == '0) ? CRC_IDLE : CRC_OTHER;
          endcase
          if (idx_r == 3'(FRAME_LEN - 1)) begin
            out_last_nxt = 1'b1;
            state_nxt    = BK_IDLE;
          end
          idx_nxt = idx_r + 3'd1;
        end
      end

      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= BK_IDLE;
      idx_r         <= '0;
      wait_active_r <= 1'b0;
      bytes_rem_r   <= '0;
      cap_started_r <= 1'b0;
      tmo_left_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      wait_active_r <= wait_active_nxt;
      bytes_rem_r   <= bytes_rem_nxt;
      cap_started_r <= cap_started_nxt;
      tmo_left_r    <= tmo_left_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    prod_r     <= prod_nxt;
    dec_r      <= dec_nxt;
    arg_r      <= arg_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

>>> rtl/sdspi_checker.sv
// sdspi_checker: assertions on the result channel of the engine, bound to the top level
// depends on sdspi_pkg and sd_spi_command_response_engine_unit

module sdspi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last
);
  import sdspi_pkg::*;

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // nothing offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_TIMEOUT |-> out_byte == 8'h00 && out_last)
    else $error("malformed timeout result");

  // closing byte of a frame is always a crc byte
  a_frame_crc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FRAME && out_last |->
      out_byte == CRC_IDLE || out_byte == CRC_OTHER)
    else $error("frame closed without crc byte");

endmodule

bind sd_spi_command_response_engine_unit sdspi_checker u_sdspi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.out_kind),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last)
);

>>> tb/sv/sd_spi_command_response_engine_unit_test.sv
// self-checking bench for the sd spi command/response engine: frames, waits, captured bytes
// depends on sdspi_pkg, sdspi_in_if/sdspi_out_if and sd_spi_command_response_engine_unit

import sdspi_pkg::*;

typedef struct {
  logic [1:0]  action;
  logic [5:0]  command_index;
  logic [1:0]  address_mode;
  logic [31:0] sector;
  logic [6:0]  block;
  logic [5:0]  response_length;
  logic [7:0]  rx_byte;
} sd_item_t;

typedef struct {
  logic [1:0] kind;
  logic [7:0] data;
  logic       last;
} sd_byte_t;

class sdspi_response_scoreboard;
  sd_byte_t   expected_bytes[$];
  int         errors;
  // register copies
  logic [3:0] blk_log2;
  logic [7:0] sec_blocks;
  logic [7:0] rsp_timeout;
  // collector copy
  bit         armed;
  bit         capturing;
  logic [5:0] left;
  logic [7:0] tmo_left;

  function new();
    blk_log2    = RST_BLOCK_LEN_LOG2;
    sec_blocks  = RST_SECTOR_BLOCKS;
    rsp_timeout = RST_RESPONSE_TIMEOUT;
    armed       = 1'b0;
    capturing   = 1'b0;
    left        = '0;
    tmo_left    = '0;
    errors      = 0;
  endfunction

  function void set_register(logic [1:0] idx, logic [31:0] value);
    case (idx)
      REG_BLOCK_LEN_LOG2:   blk_log2 = value[3:0];
      REG_SECTOR_BLOCKS:    sec_blocks = value[7:0];
      REG_RESPONSE_TIMEOUT: rsp_timeout = value[7:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] command_argument(logic [1:0] mode, logic [31:0] sector,
                                         logic [6:0] block);
    logic [31:0] v;
    case (mode)
      AM_BLOCK: begin
        v = sector * {24'd0, sec_blocks} + {25'd0, block};
        return v << blk_log2;
      end
      AM_SECTOR_END: begin
        v = (sector + 32'd1) * {24'd0, sec_blocks};
        v = v << blk_log2;
        return v - 32'd1;
      end
      default: return 32'd0;
    endcase
  endfunction

  function void add_expected(logic [1:0] kind, logic [7:0] data, logic last);
    sd_byte_t b;
    b.kind = kind;
    b.data = data;
    b.last = last;
    expected_bytes.push_back(b);
  endfunction

  // advance the predicted engine by one accepted input transfer
  function void take_item(sd_item_t it);
    logic [31:0] arg;
    logic [5:0]  len;
    case (it.action)
      ACT_SEND: begin
        arg = command_argument(it.address_mode, it.sector, it.block);
        add_expected(KIND_FRAME, CMD_START_BIT | {2'b00, it.command_index}, 1'b0);
        add_expected(KIND_FRAME, arg[31:24], 1'b0);
        add_expected(KIND_FRAME, arg[23:16], 1'b0);
        add_expected(KIND_FRAME, arg[15:8], 1'b0);
        add_expected(KIND_FRAME, arg[7:0], 1'b0);
        add_expected(KIND_FRAME, (it.command_index == 6'd0) ? CRC_IDLE : CRC_OTHER, 1'b1);
      end
      ACT_WAIT: begin
        len = (it.response_length == 6'd0) ? 6'd1 : it.response_length;
        if (len > LEN_CAP) len = LEN_CAP;
        capturing = 1'b0;
        if (rsp_timeout == 8'd0) begin
          armed    = 1'b0;
          left     = '0;
          tmo_left = '0;
          add_expected(KIND_TIMEOUT, 8'd0, 1'b1);
        end else begin
          armed    = 1'b1;
          left     = len;
          tmo_left = rsp_timeout;
        end
      end
      ACT_RX: begin
        if (armed) begin
          if (!capturing && it.rx_byte == IDLE_BYTE) begin
            if (tmo_left != 8'd0) tmo_left--;
            if (tmo_left == 8'd0) begin
              armed = 1'b0;
              left  = '0;
              add_expected(KIND_TIMEOUT, 8'd0, 1'b1);
            end
          end else begin
            capturing = 1'b1;
            if (left != 6'd0) left--;
            if (left == 6'd0) begin
              armed     = 1'b0;
              capturing = 1'b0;
              add_expected(KIND_CAPTURE, it.rx_byte, 1'b1);
            end else begin
              add_expected(KIND_CAPTURE, it.rx_byte, 1'b0);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_byte(logic [1:0] kind, logic [7:0] data, logic last);
    sd_byte_t b;
    if (expected_bytes.size() == 0) begin
      if (errors < 10)
        $display("unexpected result: kind %0d byte %02h last %0d", kind, data, last);
      errors++;
      return;
    end
    b = expected_bytes.pop_front();
    if (kind !== b.kind || data !== b.data || last !== b.last) begin
      if (errors < 10)
        $display("mismatch: expected kind %0d byte %02h last %0d, got kind %0d byte %02h last %0d",
                 b.kind, b.data, b.last, kind, data, last);
      errors++;
    end
  endfunction
endclass

module sd_spi_command_response_engine_unit_test;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam logic [1:0] AM_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT = 1000;
  localparam int         DIRECTED    = 16;
  localparam int         PER_PHASE   = 43;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  sdspi_in_if  in_ch ();
  sdspi_out_if out_ch ();

  sdspi_response_scoreboard sb;
  bit calm;
  int items_sent;

  sd_spi_command_response_engine_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    sd_item_t it;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.action          = in_ch.action;
      it.command_index   = in_ch.command_index;
      it.address_mode    = in_ch.address_mode;
      it.sector          = in_ch.sector;
      it.block           = in_ch.block;
      it.response_length = in_ch.response_length;
      it.rx_byte         = in_ch.rx_byte;
      sb.take_item(it);
    end
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_byte(out_ch.out_kind, out_ch.out_byte, out_ch.out_last);
  end

  // quiet stretches of a correct run stay far below the limit
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[sd_spi_command_response_engine_unit] ERROR");
    $finish;
  end

  function automatic sd_item_t item_of(logic [1:0] action, logic [5:0] cmd, logic [1:0] mode,
                                       logic [31:0] sector, logic [6:0] block,
                                       logic [5:0] len, logic [7:0] rx);
    sd_item_t it;
    it.action          = action;
    it.command_index   = cmd;
    it.address_mode    = mode;
    it.sector          = sector;
    it.block           = block;
    it.response_length = len;
    it.rx_byte         = rx;
    return it;
  endfunction

  function automatic sd_item_t random_item();
    sd_item_t it;
    it.action          = 2'($urandom_range(3));
    it.command_index   = 6'($urandom_range(63));
    it.address_mode    = 2'($urandom_range(3));
    it.sector          = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : 32'($urandom);
    it.block           = 7'($urandom_range(127));
    it.response_length = 6'($urandom_range(63));
    it.rx_byte         = 8'($urandom_range(255));
    return it;
  endfunction

  // valid stays high from one transfer to the next unless a gap is drawn
  task automatic push_item(input sd_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid           <= 1'b1;
    in_ch.action          <= it.action;
    in_ch.command_index   <= it.command_index;
    in_ch.address_mode    <= it.address_mode;
    in_ch.sector          <= it.sector;
    in_ch.block           <= it.block;
    in_ch.response_length <= it.response_length;
    in_ch.rx_byte         <= it.rx_byte;
    do @(posedge clk); while (!in_ch.ready);
    if (it.action != ACT_UNUSED) items_sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
  endtask

  // drain every expected result, then give the queue time to retire silent items
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [3:0] log2, input logic [7:0] sblk,
                               input logic [7:0] tmo);
    settle();
    reg_write(REG_BLOCK_LEN_LOG2, {28'd0, log2});
    reg_write(REG_SECTOR_BLOCKS, {24'd0, sblk});
    reg_write(REG_RESPONSE_TIMEOUT, {24'd0, tmo});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_frame();
    sd_item_t it;
    it = random_item();
    it.action = ACT_SEND;
    push_item(it);
  endtask

  // start a wait, idle bytes, then (unless they run out the timeout) a response that may be cut short
  task automatic run_exchange();
    sd_item_t it;
    int tmo;
    int len;
    int lead;
    tmo = sb.rsp_timeout;
    it = random_item();
    it.action = ACT_WAIT;
    if ($urandom_range(9) != 0) it.response_length = 6'($urandom_range(1, 6));
    push_item(it);
    len = (it.response_length == 0) ? 1 : it.response_length;
    if (len > LEN_CAP_INT) len = LEN_CAP_INT;
    if (tmo == 0)
      lead = 0;
    else if (tmo <= 12 && $urandom_range(3) == 0)
      lead = tmo;
    else
      lead = $urandom_range((tmo - 1 < 5) ? tmo - 1 : 5);
    for (int k = 0; k < lead; k++) begin
      it = random_item();
      it.action = ACT_RX;
      it.rx_byte = IDLE_BYTE;
      push_item(it);
    end
    if (tmo != 0 && lead == tmo) return;
    if (len > 1 && $urandom_range(5) == 0) len = $urandom_range(1, len - 1);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(9) == 0) send_frame();
      it = random_item();
      it.action = ACT_RX;
      if (k == 0)
        it.rx_byte = 8'($urandom_range(254));
      else if ($urandom_range(5) == 0)
        it.rx_byte = IDLE_BYTE;
      push_item(it);
    end
  endtask

  task automatic one_round();
    int r;
    r = $urandom_range(9);
    if (r < 6)
      run_exchange();
    else if (r < 8)
      send_frame();
    else
      push_item(random_item());
  endtask

  initial begin
    sb         = new();
    calm       = 1'b0;
    items_sent = 0;
    rst_n                 <= 1'b0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.action          <= ACT_SEND;
    in_ch.command_index   <= '0;
    in_ch.address_mode    <= AM_ZERO;
    in_ch.sector          <= '0;
    in_ch.block           <= '0;
    in_ch.response_length <= '0;
    in_ch.rx_byte         <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under the reset register values
    push_item(item_of(ACT_SEND, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, 8'd0));
    push_item(item_of(ACT_SEND, 6'd63, AM_BLOCK, 32'hFFFF_FFFF, 7'd127, 6'd63, 8'hFF));
    push_item(item_of(ACT_SEND, 6'd17, AM_SECTOR_END, 32'd0, 7'd0, 6'd1, 8'd0));
    push_item(item_of(ACT_SEND, 6'd24, AM_UNUSED, $urandom, 7'd5, 6'd1, 8'd0));
    push_item(item_of(ACT_UNUSED, 6'd9, AM_BLOCK, 32'd1, 7'd1, 6'd1, 8'd1));
    // received byte with the collector idle
    push_item(item_of(ACT_RX, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd1, 8'h00));
    // zero length behaves as one byte
    push_item(item_of(ACT_WAIT, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, 8'd0));
    push_item(item_of(ACT_RX, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, 8'h00));
    // oversized length, then a frame while armed, then a restart while armed
    push_item(item_of(ACT_WAIT, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd63, 8'd0));
    push_item(item_of(ACT_RX, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, IDLE_BYTE));
    push_item(item_of(ACT_RX, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, 8'hAA));
    push_item(item_of(ACT_SEND, 6'd55, AM_BLOCK, 32'd3, 7'd2, 6'd0, 8'd0));
    push_item(item_of(ACT_WAIT, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd2, 8'd0));
    push_item(item_of(ACT_RX, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, IDLE_BYTE));
    push_item(item_of(ACT_RX, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, 8'h80));
    // idle byte after capture began is data, not timeout
    push_item(item_of(ACT_RX, 6'd0, AM_ZERO, 32'd0, 7'd0, 6'd0, IDLE_BYTE));

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: apply_setting(4'd0, 8'd128, 8'd1);
        1: apply_setting(4'd15, 8'd255, 8'd254);
        2: apply_setting(4'($urandom_range(15)), 8'd0, 8'd0);
        3: apply_setting(4'($urandom_range(15)), 8'($urandom_range(1, 128)),
                         8'($urandom_range(2, 12)));
        default: apply_setting(4'($urandom_range(15)), 8'($urandom_range(1, 8)),
                               8'($urandom_range(1, 6)));
      endcase
      calm = (p == 3);
      while (items_sent < DIRECTED + PER_PHASE * (p + 1)) one_round();
    end
    calm = 1'b0;

    settle();
    if (sb.errors == 0 && sb.expected_bytes.size() == 0)
      $display("[sd_spi_command_response_engine_unit] OK");
    else
      $display("[sd_spi_command_response_engine_unit] ERROR");
    $finish;
  end

endmodule
